FILE: rtl/cbpm_pkg.sv
`timescale 1ns / 1ps

package cbpm_pkg;

  // Operation codes carried with each input transaction.
  typedef enum logic [1:0] {
    OP_TEXT  = 2'd0,
    OP_START = 2'd1,
    OP_MAP   = 2'd2,
    OP_NONE  = 2'd3
  } op_e;

  // Query sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_STEP,
    ST_CMP,
    ST_OFF
  } state_e;

  // Result kinds.
  localparam logic KIND_BYTE = 1'b0;
  localparam logic KIND_MAP  = 1'b1;

  // Reset value of the invisible byte register (ASCII space).
  localparam logic [7:0] INVISIBLE_RESET = 8'd32;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;    // input transaction taken this cycle
    logic rd_mid;    // read the table at the search midpoint instead of the low bound
    logic step_cmp;  // narrow the search bounds using the entry just read
    logic load_map;  // load the mapped position into the output register
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic out_free;     // output register can take a result this cycle
    logic table_empty;  // no pairs recorded
    logic narrow;       // search bounds have closed to a single entry
  } status_t;

endpackage

FILE: rtl/cbpm_ctrl.sv
`timescale 1ns / 1ps

module cbpm_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic [1:0]         operation_i,
  input  cbpm_pkg::status_t  status_i,
  output logic               in_ready_o,
  output cbpm_pkg::cmd_t     cmd_o
);
  import cbpm_pkg::*;

  state_e state_q, state_d;
  logic   take;

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and commands. Text bytes, start operations and queries on an empty
  // table finish in the cycle they are taken; any other query walks the table by binary search.
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    take       = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o   = status_i.out_free;
        take         = in_valid_i && status_i.out_free;
        cmd_o.accept = take;
        if (take && (operation_i == OP_MAP) && !status_i.table_empty) begin
          state_d = ST_STEP;
        end
      end
      ST_STEP: begin
        cmd_o.rd_mid = !status_i.narrow;
        state_d      = status_i.narrow ? ST_OFF : ST_CMP;
      end
      ST_CMP: begin
        cmd_o.step_cmp = 1'b1;
        state_d        = ST_STEP;
      end
      ST_OFF: begin
        if (status_i.out_free) begin
          cmd_o.load_map = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

FILE: rtl/cbpm_dp.sv
`timescale 1ns / 1ps

module cbpm_dp #(
  parameter int MAX_PAIRS    = 1024,
  parameter int MAX_TEXT_LEN = 65536
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  input  logic [7:0]         cfg_data_i,
  input  logic [1:0]         operation_i,
  input  logic [7:0]         text_byte_i,
  input  logic [15:0]        query_position_i,
  input  logic               out_ready_i,
  input  cbpm_pkg::cmd_t     cmd_i,
  output cbpm_pkg::status_t  status_o,
  output logic               out_valid_o,
  output logic               result_kind_o,
  output logic [7:0]         kept_byte_o,
  output logic [15:0]        collapsed_index_o,
  output logic [16:0]        original_position_o,
  output logic               overflow_o
);
  import cbpm_pkg::*;

  localparam int TW   = $clog2(MAX_TEXT_LEN + 1);  // text counters
  localparam int PCW  = $clog2(MAX_PAIRS + 1);     // pair count and search bounds
  localparam int AW   = $clog2(MAX_PAIRS);         // table address
  localparam int EW   = 2 * TW;                    // table entry: position and offset
  localparam int CMPW = TW + 16;
  localparam int SUMW = TW + 17;

  // Configuration and text state.
  logic [7:0]     inv_q;
  logic           run_q,   run_d;
  logic [TW-1:0]  drop_q,  drop_d;
  logic [TW-1:0]  wr_q,    wr_d;
  logic [TW-1:0]  total_q, total_d;
  logic [PCW-1:0] pc_q,    pc_d;
  logic           ovf_q,   ovf_d;

  // Pair table and its registered read port.
  logic [EW-1:0]  pair_mem_q [MAX_PAIRS];
  logic [EW-1:0]  rd_q;
  logic [AW-1:0]  rd_addr;

  // Search registers.
  logic [15:0]    qry_q;
  logic [PCW-1:0] lo_q, hi_q;
  logic [PCW:0]   mid_sum;
  logic [PCW-1:0] mid;

  // Output register.
  logic           out_valid_q, out_valid_d;
  logic           out_kind_q;
  logic [7:0]     out_byte_q;
  logic [15:0]    out_idx_q;
  logic [16:0]    out_orig_q;
  logic           out_ovf_q;

  logic           out_free;
  logic           text_acc, start_acc, map_acc;
  logic           too_long, is_inv, full;
  logic           kept, store;
  logic [TW-1:0]  rd_pos, rd_off;
  logic           pos_le;
  logic [SUMW-1:0] orig_sum, wr_ext;

  // Decode of the accepted operation.
  assign out_free  = !out_valid_q || out_ready_i;
  assign text_acc  = cmd_i.accept && (operation_i == OP_TEXT);
  assign start_acc = cmd_i.accept && (operation_i == OP_START);
  assign map_acc   = cmd_i.accept && (operation_i == OP_MAP);

  assign too_long = (total_q == TW'(MAX_TEXT_LEN));
  assign is_inv   = (text_byte_i == inv_q);
  assign full     = (pc_q == PCW'(MAX_PAIRS));
  assign kept     = text_acc && !too_long && !is_inv;
  assign store    = kept && !run_q && !full;

  // Text counters, run tracking and the sticky overflow flag.
  always_comb begin
    run_d   = run_q;
    drop_d  = drop_q;
    wr_d    = wr_q;
    total_d = total_q;
    pc_d    = pc_q;
    ovf_d   = ovf_q;
    if (start_acc) begin
      run_d   = 1'b0;
      drop_d  = '0;
      wr_d    = '0;
      total_d = '0;
      pc_d    = '0;
      ovf_d   = 1'b0;
    end else if (text_acc) begin
      if (too_long) begin
        ovf_d = 1'b1;
      end else if (is_inv) begin
        drop_d  = drop_q + 1'b1;
        total_d = total_q + 1'b1;
        run_d   = 1'b0;
      end else begin
        wr_d    = wr_q + 1'b1;
        total_d = total_q + 1'b1;
        run_d   = 1'b1;
        if (!run_q) begin
          if (full) begin
            ovf_d = 1'b1;
          end else begin
            pc_d = pc_q + 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inv_q   <= INVISIBLE_RESET;
      run_q   <= 1'b0;
      drop_q  <= '0;
      wr_q    <= '0;
      total_q <= '0;
      pc_q    <= '0;
      ovf_q   <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        inv_q <= cfg_data_i;
      end
      run_q   <= run_d;
      drop_q  <= drop_d;
      wr_q    <= wr_d;
      total_q <= total_d;
      pc_q    <= pc_d;
      ovf_q   <= ovf_d;
    end
  end

  // Binary search address: midpoint while narrowing, low bound at the end.
  assign mid_sum = {1'b0, lo_q} + {1'b0, hi_q};
  assign mid     = mid_sum[PCW:1];
  assign rd_addr = cmd_i.rd_mid ? mid[AW-1:0] : lo_q[AW-1:0];

  // Pair table: one write port for new runs, one registered read port.
  always_ff @(posedge clk_i) begin
    if (store) begin
      pair_mem_q[pc_q[AW-1:0]] <= {wr_q, drop_q};
    end
    rd_q <= pair_mem_q[rd_addr];
  end

  assign rd_pos = rd_q[EW-1:TW];
  assign rd_off = rd_q[TW-1:0];
  assign pos_le = (CMPW'(rd_pos) <= CMPW'(qry_q));

  // Search bounds: the answer is the last entry in [lo, hi) whose position
  // is not above the query. Entry zero always has position zero.
  always_ff @(posedge clk_i) begin
    if (map_acc) begin
      qry_q <= query_position_i;
      lo_q  <= '0;
      hi_q  <= pc_q;
    end else if (cmd_i.step_cmp) begin
      if (pos_le) begin
        lo_q <= mid;
      end else begin
        hi_q <= mid;
      end
    end
  end

  assign status_o.out_free    = out_free;
  assign status_o.table_empty = (pc_q == '0);
  assign status_o.narrow      = (({1'b0, lo_q} + 1'b1) >= {1'b0, hi_q});

  assign orig_sum = SUMW'(qry_q) + SUMW'(rd_off);
  assign wr_ext   = SUMW'(wr_q);

  // Output register valid flag.
  always_comb begin
    out_valid_d = out_valid_q;
    if (kept || (map_acc && status_o.table_empty) || cmd_i.load_map) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  // Output payload.
  always_ff @(posedge clk_i) begin
    if (kept) begin
      out_kind_q <= KIND_BYTE;
      out_byte_q <= text_byte_i;
      out_idx_q  <= wr_ext[15:0];
      out_orig_q <= '0;
      out_ovf_q  <= ovf_q || (!run_q && full);
    end else if (map_acc && status_o.table_empty) begin
      out_kind_q <= KIND_MAP;
      out_byte_q <= '0;
      out_idx_q  <= '0;
      out_orig_q <= {1'b0, query_position_i};
      out_ovf_q  <= ovf_q;
    end else if (cmd_i.load_map) begin
      out_kind_q <= KIND_MAP;
      out_byte_q <= '0;
      out_idx_q  <= '0;
      out_orig_q <= orig_sum[16:0];
      out_ovf_q  <= ovf_q;
    end
  end

  assign out_valid_o         = out_valid_q;
  assign result_kind_o       = out_kind_q;
  assign kept_byte_o         = out_byte_q;
  assign collapsed_index_o   = out_idx_q;
  assign original_position_o = out_orig_q;
  assign overflow_o          = out_ovf_q;

  // The pair count never passes the table depth.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pc_q <= PCW'(MAX_PAIRS))
    else $error("pair count beyond table depth");

  // Bytes taken equal kept plus dropped bytes.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    total_q == TW'(wr_q + drop_q))
    else $error("text length counter out of step");

  // A narrowing step only happens while the bounds span two or more entries.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.step_cmp |-> (({1'b0, lo_q} + 1'b1) < {1'b0, hi_q}))
    else $error("search step with closed bounds");

  // A new result is never loaded over one that has not been taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (kept || cmd_i.load_map) |-> out_free)
    else $error("output register overwritten");

endmodule

FILE: rtl/collapse_byte_with_position_map.sv
`timescale 1ns / 1ps
// Text byte: result in the output register the cycle after it is taken;
// one byte per cycle while results are drained.
// Position query: binary search of the pair table, a read and then a compare per
// halving on the single registered read port.
// Reset (asynchronous, active low) clears all counters and flags and sets the
// invisible byte to 32; the pair table contents are not cleared.

module collapse_byte_with_position_map #(
  parameter int MAX_PAIRS    = 1024,
  parameter int MAX_TEXT_LEN = 65536
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [7:0]  cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  operation_i,
  input  logic [7:0]  text_byte_i,
  input  logic [15:0] query_position_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        result_kind_o,
  output logic [7:0]  kept_byte_o,
  output logic [15:0] collapsed_index_o,
  output logic [16:0] original_position_o,
  output logic        overflow_o
);
  import cbpm_pkg::*;

  cmd_t    cmd;
  status_t status;

  // The configuration register is always writable.
  assign cfg_ready_o = 1'b1;

  cbpm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .operation_i (operation_i),
    .status_i    (status),
    .in_ready_o  (in_ready_o),
    .cmd_o       (cmd)
  );

  cbpm_dp #(
    .MAX_PAIRS    (MAX_PAIRS),
    .MAX_TEXT_LEN (MAX_TEXT_LEN)
  ) u_dp (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cfg_valid_i         (cfg_valid_i),
    .cfg_data_i          (cfg_data_i),
    .operation_i         (operation_i),
    .text_byte_i         (text_byte_i),
    .query_position_i    (query_position_i),
    .out_ready_i         (out_ready_i),
    .cmd_i               (cmd),
    .status_o            (status),
    .out_valid_o         (out_valid_o),
    .result_kind_o       (result_kind_o),
    .kept_byte_o         (kept_byte_o),
    .collapsed_index_o   (collapsed_index_o),
    .original_position_o (original_position_o),
    .overflow_o          (overflow_o)
  );

endmodule
